FILE: rtl/core/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants of the sorted array bag
// Operation codes, status codes, widths and the front-to-back command type.
// ----------------------------------------------------------------------------
`default_nettype none
package sab_pkg;
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = 7;
	localparam int VAL_W = 32;
	localparam int QDEPTH = 2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_REMOVE,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic signed [VAL_W-1:0] value;
	} cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/sab_if.sv
// ----------------------------------------------------------------------------
// sab_if: valid/ready channel interfaces
// Input channel carries op and value; output channel carries the result.
// ----------------------------------------------------------------------------
`default_nettype none
interface sab_in_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [31:0] value;
	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface sab_out_if;
	logic valid;
	logic ready;
	logic found;
	logic [1:0] status;
	logic [6:0] count;
	modport source (output valid, output found, output status, output count, input ready);
	modport sink (input valid, input found, input status, input count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sab_front.sv
// ----------------------------------------------------------------------------
// sab_front: decodes beats and queues commands
// Classifies op codes (code three acts as query) into a short FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
module sab_front (
	input  wire logic clk,
	input  wire logic arst_n,
	sab_in_if.sink    in_ch,
	output sab_pkg::cmd_t cmd,
	output logic      cmd_valid,
	input  wire logic cmd_ready
);
	sab_pkg::cmd_t q_mem_q [sab_pkg::QDEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;
	sab_pkg::cmd_t dec;

	always_comb begin
		dec.value = in_ch.value;
		case (in_ch.op)
			sab_pkg::OP_ADD: dec.kind = sab_pkg::CMD_ADD;
			sab_pkg::OP_REMOVE: dec.kind = sab_pkg::CMD_REMOVE;
			default: dec.kind = sab_pkg::CMD_QUERY;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/sab_back.sv
// ----------------------------------------------------------------------------
// sab_back: systolic sorted row
// Every cell compares against the command at once and the whole row shifts together.
// ----------------------------------------------------------------------------
`default_nettype none
module sab_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sab_pkg::cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	sab_out_if.source out_ch
);
	localparam int D = sab_pkg::DEPTH;
	logic signed [sab_pkg::VAL_W-1:0] cell_q [D];
	logic [sab_pkg::CNT_W-1:0] fill_q;
	logic [D-1:0] occ, lt, eq_v, shl;
	logic found, full, do_add, do_rem, take;
	logic [1:0] st;
	logic [sab_pkg::CNT_W-1:0] fill_n;
	logic res_valid_q, res_found_q;
	logic [1:0] res_status_q;
	logic [sab_pkg::CNT_W-1:0] res_count_q;

	always_comb begin
		for (int i = 0; i < D; i++) begin
			occ[i] = (sab_pkg::CNT_W'(i) < fill_q);
			lt[i] = occ[i] && (cell_q[i] < cmd.value);
			eq_v[i] = occ[i] && (cell_q[i] == cmd.value);
		end
	end

	// lower bound entry equal <=> some occupied entry equals value
	assign found = |eq_v;
	assign full = (fill_q >= sab_pkg::CNT_W'(D));
	assign cmd_ready = !res_valid_q || out_ch.ready;
	assign take = cmd_valid && cmd_ready;
	assign do_add = take && cmd.kind == sab_pkg::CMD_ADD && !full;
	assign do_rem = take && cmd.kind == sab_pkg::CMD_REMOVE && found;

	// shl[i]: cell i is at or beyond the removed position (first match)
	always_comb begin
		for (int i = 0; i < D; i++) shl[i] = occ[i] && !lt[i];
	end

	always_comb begin
		fill_n = fill_q;
		if (do_add) fill_n = fill_q + 1'b1;
		else if (do_rem) fill_n = fill_q - 1'b1;
		case (cmd.kind)
			sab_pkg::CMD_ADD: st = full ? sab_pkg::ST_FULL : sab_pkg::ST_DONE;
			default: st = found ? sab_pkg::ST_DONE : sab_pkg::ST_ABSENT;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < D; i++) begin
			if (do_add) begin
				if (i > 0 && !lt[i-1 < 0 ? 0 : i-1] && i != 0 && (i == 0 ? 1'b0 : 1'b1))
					cell_q[i] <= cell_q[i-1 < 0 ? 0 : i-1];
				else if (!lt[i] && (i == 0 || lt[i-1 < 0 ? 0 : i-1]))
					cell_q[i] <= cmd.value;
			end else if (do_rem) begin
				if (shl[i] && i < D-1)
					cell_q[i] <= cell_q[i+1 > D-1 ? D-1 : i+1];
			end
		end
		if (take) begin
			res_found_q <= found;
			res_status_q <= st;
			res_count_q <= fill_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_n;
			if (take) res_valid_q <= 1'b1;
			else if (out_ch.ready) res_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.found = res_found_q;
	assign out_ch.status = res_status_q;
	assign out_ch.count = res_count_q;
endmodule
`default_nettype wire

FILE: rtl/core/sorted_array_bag_unit.sv
// Path from input beat to result beat: command queue, then row update and result register.
// Throughput: one beat per cycle while the output is ready; the row compares all cells and shifts at once.
// A 2-entry command queue decouples decode from the row; a result register
// holds the outgoing beat while the next command is taken.
// Reset (arst_n low): fill count, queue and result valid clear; cells are
// left unwritten and never read beyond the fill count.
`default_nettype none
module sorted_array_bag_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	sab_in_if.sink    in_ch,
	sab_out_if.source out_ch
);
	// decoded command between front and back
	sab_pkg::cmd_t cmd;
	logic cmd_valid, cmd_ready;

	sab_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	// back: sorted row of cells, fill count and result register
	sab_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

FILE: tb/sorted_array_bag_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_array_bag_unit_tb: self-checking bench for the sorted array bag
// Drives add, query and remove beats under varied backpressure, predicts each
// result with a software copy of the ordered store and checks every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sorted_array_bag_unit_tb;

	typedef struct packed {
		logic       found;
		logic [1:0] status;
		logic [6:0] count;
	} bag_result_t;

	// spare op code, decoded by the block as a query
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sab_in_if  in_ch ();
	sab_out_if out_ch ();

	sorted_array_bag_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: ascending copy of the store
	logic signed [31:0] bag_vals [$];
	bag_result_t        pending_results [$];

	int  errors = 0;
	int  cycles = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_cycles = 0;
	localparam int CYCLE_LIMIT = 400000;

	// predict one operation and update the model store
	function automatic bag_result_t apply_bag_op(logic [1:0] op, logic signed [31:0] v);
		bag_result_t r;
		int pos;
		logic hit;
		pos = 0;
		while (pos < bag_vals.size() && bag_vals[pos] < v)
			pos++;
		hit = (pos < bag_vals.size()) && (bag_vals[pos] == v);
		r.found = hit;
		if (op == sab_pkg::OP_ADD) begin
			if (bag_vals.size() >= sab_pkg::DEPTH) begin
				r.status = sab_pkg::ST_FULL;
			end else begin
				bag_vals.insert(pos, v);
				r.status = sab_pkg::ST_DONE;
			end
		end else if (op == sab_pkg::OP_REMOVE) begin
			if (hit) begin
				bag_vals.delete(pos);
				r.status = sab_pkg::ST_DONE;
			end else begin
				r.status = sab_pkg::ST_ABSENT;
			end
		end else begin
			// query, and the unused code three behaves as one
			r.status = hit ? sab_pkg::ST_DONE : sab_pkg::ST_ABSENT;
		end
		r.count = 7'(bag_vals.size());
		return r;
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = sab_pkg::OP_QUERY;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off counted here
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		bag_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_ch.found !== exp_r.found) begin
					$error("found: expected %0d actual %0d", exp_r.found, out_ch.found);
					errors++;
				end
				if (out_ch.status !== exp_r.status) begin
					$error("status: expected %0d actual %0d", exp_r.status, out_ch.status);
					errors++;
				end
				if (out_ch.count !== exp_r.count) begin
					$error("count: expected %0d actual %0d", exp_r.count, out_ch.count);
					errors++;
				end
			end
		end
	end

	// offer one beat, hold it until accepted; valid stays up for the next beat
	task automatic send_op(logic [1:0] op, logic signed [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(apply_bag_op(op, v));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// values drawn mostly from a small pool so hits and duplicates are common
	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return $signed($urandom_range(15)) - 8;
		else if (sel == 6 && bag_vals.size() > 0)
			return bag_vals[$urandom_range(bag_vals.size() - 1)];
		else if (sel == 7)
			return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
		return $signed($urandom());
	endfunction

	task automatic test_directed();
		send_op(sab_pkg::OP_QUERY, 0);              // query on empty bag
		send_op(sab_pkg::OP_REMOVE, 5);             // remove from empty
		send_op(sab_pkg::OP_ADD, 32'sh7fffffff);
		send_op(sab_pkg::OP_ADD, 32'sh80000000);
		send_op(sab_pkg::OP_ADD, 0);
		send_op(sab_pkg::OP_ADD, 0);                // duplicate copy
		send_op(sab_pkg::OP_ADD, -1);
		send_op(sab_pkg::OP_QUERY, 32'sh80000000);
		send_op(sab_pkg::OP_QUERY, 32'sh7fffffff);
		send_op(sab_pkg::OP_QUERY, 1);
		send_op(OP_SPARE, 0);                       // unused code acts as query
		send_op(OP_SPARE, 7);
		send_op(sab_pkg::OP_REMOVE, 32'sh80000000); // match at position zero
		send_op(sab_pkg::OP_REMOVE, 0);
		send_op(sab_pkg::OP_REMOVE, 0);
		send_op(sab_pkg::OP_REMOVE, 0);             // gone now
		send_op(sab_pkg::OP_REMOVE, 32'sh7fffffff);
		send_op(sab_pkg::OP_REMOVE, -1);
		wait_drained();
	endtask

	// fill to capacity, reject adds, then empty again
	task automatic test_full();
		for (int i = 0; i < sab_pkg::DEPTH + 3; i++)
			send_op(sab_pkg::OP_ADD, $signed($urandom()));
		send_op(sab_pkg::OP_ADD, bag_vals[0]);      // full, but found reports presence
		while (bag_vals.size() > 0)
			send_op(sab_pkg::OP_REMOVE, bag_vals[$urandom_range(bag_vals.size() - 1)]);
		wait_drained();
	endtask

	task automatic test_random(int n, int idle, int stall);
		int r;
		logic [1:0] op;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			// lean toward adds when nearly empty, removes when nearly full
			if (r < 40 + (bag_vals.size() < 8 ? 20 : 0) - (bag_vals.size() > 56 ? 25 : 0))
				op = sab_pkg::OP_ADD;
			else if (r < 70)
				op = sab_pkg::OP_REMOVE;
			else if (r < 95)
				op = sab_pkg::OP_QUERY;
			else
				op = OP_SPARE;
			send_op(op, pick_value());
		end
		wait_drained();
	endtask

	// long receiver hold-off so the block fills and stalls its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_cycles <= 60;
		for (int i = 0; i < 30; i++)
			send_op(2'($urandom_range(2)), pick_value());
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full();
		test_random(450, 0, 0);
		test_random(450, 55, 0);
		test_random(450, 0, 55);
		test_random(450, 35, 35);
		test_backpressure();
		// sender pauses until every result is in, then resumes
		test_random(100, 10, 10);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/sab_pkg.sv
rtl/core/sab_if.sv
rtl/core/sab_front.sv
rtl/core/sab_back.sv
rtl/core/sorted_array_bag_unit.sv
tb/sorted_array_bag_unit_tb.sv
